>>> rtl/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// shared codes, constants and request/result types of the moesi
// snoop transition unit
// ----------------------------------------------------------------------------
package mst_pkg;

    // caches on the bus, ports always carry four line states
    localparam int NUM_CACHES = 4;
    localparam int MAX_CACHES = 4;

    localparam int ST_W    = 3;
    localparam int OP_W    = 3;
    localparam int REQR_W  = 2;
    localparam int ADDR_W  = 32;
    localparam int BSIZE_W = 13;
    localparam int CYC_W   = 12;
    localparam int INV_W   = 2;
    localparam int TRAF_W  = 15;

    // line states
    localparam logic [ST_W-1:0] ST_I = 3'd0;
    localparam logic [ST_W-1:0] ST_S = 3'd1;
    localparam logic [ST_W-1:0] ST_E = 3'd2;
    localparam logic [ST_W-1:0] ST_O = 3'd3;
    localparam logic [ST_W-1:0] ST_M = 3'd4;

    // request operations
    localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
    localparam logic [OP_W-1:0] OP_RD_HIT  = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_HIT  = 3'd2;
    localparam logic [OP_W-1:0] OP_RD_MISS = 3'd3;
    localparam logic [OP_W-1:0] OP_WR_MISS = 3'd4;
    localparam logic [OP_W-1:0] OP_EVICT   = 3'd5;

    localparam logic [CYC_W-1:0]   MISS_CYCLES     = 12'd100;
    localparam logic [BSIZE_W-1:0] BLOCK_BYTES_RST = 13'd32;

    typedef struct packed {
        logic [OP_W-1:0]   req_type;
        logic [REQR_W-1:0] requester;
        logic [ADDR_W-1:0] block_address;
        logic [ST_W-1:0]   state_cache0;
        logic [ST_W-1:0]   state_cache1;
        logic [ST_W-1:0]   state_cache2;
        logic [ST_W-1:0]   state_cache3;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] out_address;
        logic [ST_W-1:0]   new_state0;
        logic [ST_W-1:0]   new_state1;
        logic [ST_W-1:0]   new_state2;
        logic [ST_W-1:0]   new_state3;
        logic [CYC_W-1:0]  blocked_cycles;
        logic [INV_W-1:0]  invalidations;
        logic [TRAF_W-1:0] traffic_bytes;
        logic              writeback;
    } t_rsp;

endpackage

>>> rtl/mst_if.sv
// ----------------------------------------------------------------------------
// mst request and result channels
// valid/ready channels carrying one snoop request or one transition result
// ----------------------------------------------------------------------------
interface mst_req_if;
    logic                          valid;
    logic                          ready;
    logic [mst_pkg::OP_W-1:0]      req_type;
    logic [mst_pkg::REQR_W-1:0]    requester;
    logic [mst_pkg::ADDR_W-1:0]    block_address;
    logic [mst_pkg::ST_W-1:0]      state_cache0;
    logic [mst_pkg::ST_W-1:0]      state_cache1;
    logic [mst_pkg::ST_W-1:0]      state_cache2;
    logic [mst_pkg::ST_W-1:0]      state_cache3;

    modport source (
        output valid, req_type, requester, block_address,
               state_cache0, state_cache1, state_cache2, state_cache3,
        input  ready
    );
    modport sink (
        input  valid, req_type, requester, block_address,
               state_cache0, state_cache1, state_cache2, state_cache3,
        output ready
    );
endinterface

interface mst_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mst_pkg::ADDR_W-1:0]    out_address;
    logic [mst_pkg::ST_W-1:0]      new_state0;
    logic [mst_pkg::ST_W-1:0]      new_state1;
    logic [mst_pkg::ST_W-1:0]      new_state2;
    logic [mst_pkg::ST_W-1:0]      new_state3;
    logic [mst_pkg::CYC_W-1:0]     blocked_cycles;
    logic [mst_pkg::INV_W-1:0]     invalidations;
    logic [mst_pkg::TRAF_W-1:0]    traffic_bytes;
    logic                          writeback;

    modport source (
        output valid, out_address, new_state0, new_state1, new_state2, new_state3,
               blocked_cycles, invalidations, traffic_bytes, writeback,
        input  ready
    );
    modport sink (
        input  valid, out_address, new_state0, new_state1, new_state2, new_state3,
               blocked_cycles, invalidations, traffic_bytes, writeback,
        output ready
    );
endinterface

>>> rtl/moesi_snoop_transition_unit.sv
// ----------------------------------------------------------------------------
// moesi_snoop_transition_unit
// moesi coherence transition unit for a four-cache snooping bus
// ----------------------------------------------------------------------------
// usage:
//   i_req carries one snoop request (operation, requester, block address and
//   the present line state in each cache); o_rsp returns one result per
//   request with the new line states, blocked bus cycles, invalidation count,
//   dirty traffic bytes and the eviction write-back flag.
//   i_cfg_we/i_cfg_wdata set the block size in bytes; write it only while no
//   request is in flight.
// timing:
//   a request is taken into an input register, the transition logic feeds the
//   result register, and o_rsp is driven from the result register. one
//   request per cycle is sustained while o_rsp.ready stays high.
// reset:
//   i_rst_n (synchronous, active low) empties both registers and sets the
//   block size to 32 bytes.
// back-pressure:
//   while o_rsp.ready is low the result holds; the input register still takes
//   one more request, after that i_req.ready drops until the result moves.
// ----------------------------------------------------------------------------
module moesi_snoop_transition_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mst_pkg::BSIZE_W-1:0]  i_cfg_wdata,
    mst_req_if.sink                      i_req,
    mst_rsp_if.source                    o_rsp
);

    logic                          r_s1_vld, n_s1_vld;
    logic                          r_s2_vld, n_s2_vld;
    mst_pkg::t_req                 r_s1;
    mst_pkg::t_rsp                 r_s2;
    mst_pkg::t_rsp                 xfer_rsp;
    logic [mst_pkg::BSIZE_W-1:0]   r_block_bytes;
    logic                          s1_rdy;
    logic                          s2_rdy;
    mst_pkg::t_req                 in_req;

    assign s2_rdy  = !r_s2_vld || o_rsp.ready;
    assign s1_rdy  = !r_s1_vld || s2_rdy;
    assign i_req.ready = s1_rdy;

    assign n_s1_vld = s1_rdy ? i_req.valid : r_s1_vld;
    assign n_s2_vld = s2_rdy ? r_s1_vld : r_s2_vld;

    always_comb begin
        in_req.req_type      = i_req.req_type;
        in_req.requester     = i_req.requester;
        in_req.block_address = i_req.block_address;
        in_req.state_cache0  = i_req.state_cache0;
        in_req.state_cache1  = i_req.state_cache1;
        in_req.state_cache2  = i_req.state_cache2;
        in_req.state_cache3  = i_req.state_cache3;
    end

    mst_xfer u_xfer (
        .i_req         (r_s1),
        .i_block_bytes (r_block_bytes),
        .o_rsp         (xfer_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld      <= 1'b0;
            r_s2_vld      <= 1'b0;
            r_block_bytes <= mst_pkg::BLOCK_BYTES_RST;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= n_s2_vld;
            if (i_cfg_we) begin
                r_block_bytes <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && s1_rdy) begin
            r_s1 <= in_req;
        end
        if (r_s1_vld && s2_rdy) begin
            r_s2 <= xfer_rsp;
        end
    end

    assign o_rsp.valid          = r_s2_vld;
    assign o_rsp.out_address    = r_s2.out_address;
    assign o_rsp.new_state0     = r_s2.new_state0;
    assign o_rsp.new_state1     = r_s2.new_state1;
    assign o_rsp.new_state2     = r_s2.new_state2;
    assign o_rsp.new_state3     = r_s2.new_state3;
    assign o_rsp.blocked_cycles = r_s2.blocked_cycles;
    assign o_rsp.invalidations  = r_s2.invalidations;
    assign o_rsp.traffic_bytes  = r_s2.traffic_bytes;
    assign o_rsp.writeback      = r_s2.writeback;

`ifndef SYNTHESIS
    // a request in the input register always reaches the result register
    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && s2_rdy) |=> r_s2_vld)
        else $error("request lost between input and result register");

    // an eviction never blocks the bus nor invalidates
    a_evict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2.writeback) |->
        (r_s2.blocked_cycles == '0 && r_s2.invalidations == '0 && r_s2.traffic_bytes == '0))
        else $error("eviction result carries bus cost");

    // after an invalidating write only the requester holds the line, as modified
    a_inval_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2.invalidations != '0) |->
        ((r_s2.new_state0 != mst_pkg::ST_I) + (r_s2.new_state1 != mst_pkg::ST_I) +
         (r_s2.new_state2 != mst_pkg::ST_I) + (r_s2.new_state3 != mst_pkg::ST_I)) == 1)
        else $error("write left more than one holder");

    // the input side is never full while the result side is free
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s2_vld) |-> i_req.ready)
        else $error("input stalled with an empty result register");
`endif

endmodule

>>> rtl/mst_xfer.sv
// ----------------------------------------------------------------------------
// mst_xfer
// combinational moesi transition of one registered request into a result
// ----------------------------------------------------------------------------
module mst_xfer (
    input  mst_pkg::t_req                   i_req,
    input  logic [mst_pkg::BSIZE_W-1:0]     i_block_bytes,
    output mst_pkg::t_rsp                   o_rsp
);

    logic [mst_pkg::ST_W-1:0] raw [mst_pkg::MAX_CACHES];
    logic [mst_pkg::ST_W-1:0] st  [mst_pkg::MAX_CACHES];
    logic [mst_pkg::ST_W-1:0] nx  [mst_pkg::MAX_CACHES];
    logic [mst_pkg::OP_W-1:0] op;
    logic [2:0]               dirty_cnt;
    logic [2:0]               other_cnt;
    logic [1:0]               last_idx;
    logic [mst_pkg::INV_W-1:0] inval;
    logic                     is_miss;
    logic [15:0]              traffic_full;

    assign raw[0] = i_req.state_cache0;
    assign raw[1] = i_req.state_cache1;
    assign raw[2] = i_req.state_cache2;
    assign raw[3] = i_req.state_cache3;

    always_comb begin
        // undefined codes and absent caches read as invalid
        for (int i = 0; i < mst_pkg::MAX_CACHES; i++) begin
            st[i] = (i < mst_pkg::NUM_CACHES && raw[i] <= mst_pkg::ST_M) ?
                    raw[i] : mst_pkg::ST_I;
        end

        op = i_req.req_type;
        if (op > mst_pkg::OP_EVICT || int'(i_req.requester) >= mst_pkg::NUM_CACHES) begin
            op = mst_pkg::OP_NONE;
        end

        dirty_cnt = 3'd0;
        other_cnt = 3'd0;
        last_idx  = 2'd0;
        for (int i = 0; i < mst_pkg::MAX_CACHES; i++) begin
            if (st[i] == mst_pkg::ST_O || st[i] == mst_pkg::ST_M) begin
                dirty_cnt = dirty_cnt + 3'd1;
            end
            if (2'(i) != i_req.requester && st[i] != mst_pkg::ST_I) begin
                other_cnt = other_cnt + 3'd1;
                last_idx  = 2'(i);
            end
        end

        is_miss = (op == mst_pkg::OP_RD_MISS) || (op == mst_pkg::OP_WR_MISS);
        inval   = '0;
        for (int i = 0; i < mst_pkg::MAX_CACHES; i++) begin
            nx[i] = st[i];
        end

        case (op)
            mst_pkg::OP_RD_MISS: begin
                for (int i = 0; i < mst_pkg::MAX_CACHES; i++) begin
                    if (st[i] == mst_pkg::ST_M) begin
                        nx[i] = mst_pkg::ST_O;
                    end else if (st[i] == mst_pkg::ST_E) begin
                        nx[i] = mst_pkg::ST_S;
                    end
                end
                nx[i_req.requester] = (other_cnt != 3'd0) ? mst_pkg::ST_S : mst_pkg::ST_E;
            end
            mst_pkg::OP_WR_HIT, mst_pkg::OP_WR_MISS: begin
                for (int i = 0; i < mst_pkg::MAX_CACHES; i++) begin
                    nx[i] = mst_pkg::ST_I;
                end
                nx[i_req.requester] = mst_pkg::ST_M;
                inval = other_cnt[mst_pkg::INV_W-1:0];
            end
            mst_pkg::OP_EVICT: begin
                nx[i_req.requester] = mst_pkg::ST_I;
                // a sole remaining holder takes ownership
                if (other_cnt == 3'd1) begin
                    nx[last_idx] = (st[last_idx] == mst_pkg::ST_O) ?
                                   mst_pkg::ST_M : mst_pkg::ST_E;
                end
            end
            default: begin
            end
        endcase
    end

    assign traffic_full = 16'(i_block_bytes) * 16'(dirty_cnt);

    always_comb begin
        o_rsp.out_address   = i_req.block_address;
        o_rsp.new_state0    = nx[0];
        o_rsp.new_state1    = nx[1];
        o_rsp.new_state2    = nx[2];
        o_rsp.new_state3    = nx[3];
        o_rsp.invalidations = inval;
        o_rsp.writeback     = (op == mst_pkg::OP_EVICT);
        o_rsp.traffic_bytes = is_miss ? traffic_full[mst_pkg::TRAF_W-1:0] : '0;
        if (is_miss) begin
            o_rsp.blocked_cycles = (dirty_cnt != 3'd0) ?
                                   i_block_bytes[mst_pkg::BSIZE_W-1:1] :
                                   mst_pkg::MISS_CYCLES;
        end else if (op == mst_pkg::OP_RD_HIT || op == mst_pkg::OP_WR_HIT) begin
            o_rsp.blocked_cycles = 12'd1;
        end else begin
            o_rsp.blocked_cycles = '0;
        end
    end

endmodule

>>> test/mst_transition_checker.sv
// ----------------------------------------------------------------------------
// mst_transition_checker
// watches the request and result channels of the moesi snoop transition
// unit, predicts every result from the request and the block size in force,
// and compares results in order, field by field
// ----------------------------------------------------------------------------
module mst_transition_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mst_pkg::BSIZE_W-1:0]  i_cfg_wdata,
    mst_req_if                           i_req,
    mst_rsp_if                           i_rsp,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_fail_count
);
    import mst_pkg::*;

    logic [BSIZE_W-1:0] block_bytes = BLOCK_BYTES_RST;
    t_rsp               expected_results[$];
    int                 fail_count = 0;
    int                 checked = 0;

    function automatic t_rsp predict_transition(t_req r, logic [BSIZE_W-1:0] bsize);
        logic [ST_W-1:0] raw  [MAX_CACHES];
        logic [ST_W-1:0] line [MAX_CACHES];
        logic [OP_W-1:0] op;
        int unsigned     cycles, traffic, inval, holders, last;
        bit              dirty, others;
        int              i;
        t_rsp            res;
        raw[0] = r.state_cache0;
        raw[1] = r.state_cache1;
        raw[2] = r.state_cache2;
        raw[3] = r.state_cache3;
        cycles  = 0;
        traffic = 0;
        inval   = 0;
        holders = 0;
        last    = 0;
        dirty   = 1'b0;
        others  = 1'b0;
        // unknown state codes and absent caches read as invalid
        for (i = 0; i < MAX_CACHES; i++)
            line[i] = (i < NUM_CACHES && raw[i] <= ST_M) ? raw[i] : ST_I;
        op = r.req_type;
        if (op > OP_EVICT || int'(r.requester) >= NUM_CACHES)
            op = OP_NONE;

        case (op)
            OP_RD_HIT, OP_WR_HIT: begin
                cycles = 1;
            end
            OP_RD_MISS, OP_WR_MISS: begin
                for (i = 0; i < MAX_CACHES; i++) begin
                    if (line[i] == ST_O || line[i] == ST_M) begin
                        dirty = 1'b1;
                        traffic += int'(bsize);
                    end
                end
                cycles = dirty ? int'(bsize) / 2 : int'(MISS_CYCLES);
            end
            default: ;
        endcase

        case (op)
            OP_RD_MISS: begin
                for (i = 0; i < MAX_CACHES; i++) begin
                    if (i != int'(r.requester) && line[i] != ST_I) begin
                        others = 1'b1;
                        if (line[i] == ST_M)
                            line[i] = ST_O;
                        else if (line[i] == ST_E)
                            line[i] = ST_S;
                    end
                end
                line[r.requester] = others ? ST_S : ST_E;
            end
            OP_WR_HIT, OP_WR_MISS: begin
                for (i = 0; i < MAX_CACHES; i++) begin
                    if (i != int'(r.requester) && line[i] != ST_I) begin
                        line[i] = ST_I;
                        inval++;
                    end
                end
                line[r.requester] = ST_M;
            end
            OP_EVICT: begin
                line[r.requester] = ST_I;
                for (i = 0; i < MAX_CACHES; i++) begin
                    if (i != int'(r.requester) && line[i] != ST_I) begin
                        holders++;
                        last = i;
                    end
                end
                // a sole survivor takes ownership
                if (holders == 1)
                    line[last] = (line[last] == ST_O) ? ST_M : ST_E;
            end
            default: ;
        endcase

        res.out_address    = r.block_address;
        res.new_state0     = line[0];
        res.new_state1     = line[1];
        res.new_state2     = line[2];
        res.new_state3     = line[3];
        res.blocked_cycles = cycles[CYC_W-1:0];
        res.invalidations  = inval[INV_W-1:0];
        res.traffic_bytes  = traffic[TRAF_W-1:0];
        res.writeback      = (op == OP_EVICT);
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_req req_item;
        t_rsp want;
        if (!i_rst_n) begin
            block_bytes = BLOCK_BYTES_RST;
            expected_results.delete();
        end else begin
            // results first, so a stray result never matches a request of this edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result for address %0h with no request waiting",
                           i_rsp.out_address);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("out_address", want.out_address, i_rsp.out_address);
                    check_field("new_state0", want.new_state0, i_rsp.new_state0);
                    check_field("new_state1", want.new_state1, i_rsp.new_state1);
                    check_field("new_state2", want.new_state2, i_rsp.new_state2);
                    check_field("new_state3", want.new_state3, i_rsp.new_state3);
                    check_field("blocked_cycles", want.blocked_cycles,
                                i_rsp.blocked_cycles);
                    check_field("invalidations", want.invalidations,
                                i_rsp.invalidations);
                    check_field("traffic_bytes", want.traffic_bytes,
                                i_rsp.traffic_bytes);
                    check_field("writeback", want.writeback, i_rsp.writeback);
                    checked++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                req_item.req_type      = i_req.req_type;
                req_item.requester     = i_req.requester;
                req_item.block_address = i_req.block_address;
                req_item.state_cache0  = i_req.state_cache0;
                req_item.state_cache1  = i_req.state_cache1;
                req_item.state_cache2  = i_req.state_cache2;
                req_item.state_cache3  = i_req.state_cache3;
                expected_results.push_back(predict_transition(req_item, block_bytes));
            end
            if (i_cfg_we)
                block_bytes = i_cfg_wdata;
        end
        o_pending    <= expected_results.size();
        o_checked    <= checked;
        o_fail_count <= fail_count;
    end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench of the moesi snoop transition unit: directed corner requests,
// then random request bursts under several block sizes, with random gaps
// on the request side and stall patterns on the result side
// ----------------------------------------------------------------------------
module tb;
    import mst_pkg::*;

    // codes outside the defined sets
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
    localparam logic [ST_W-1:0] ST_RSVD5 = 3'd5;
    localparam logic [ST_W-1:0] ST_RSVD6 = 3'd6;
    localparam logic [ST_W-1:0] ST_RSVD7 = 3'd7;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 100;
    localparam int NUM_PHASES   = 6;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [BSIZE_W-1:0] i_cfg_wdata;

    mst_req_if req_ch ();
    mst_rsp_if rsp_ch ();

    int pending;
    int checked;
    int fail_count;
    int idle_cycles   = 0;
    int burst_left    = 0;
    int stall_cycle   = 0;
    int requests_sent = 0;

    moesi_snoop_transition_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    mst_transition_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side stalls: always ready, mostly ready, periodic, coin flip
    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle >> 7) % 4)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ch.ready <= ((stall_cycle % 11) < 5);
            default: rsp_ch.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("moesi_snoop_transition_unit: mismatch");
            $finish;
        end
    end

    function automatic t_req make_req(logic [OP_W-1:0] op, logic [REQR_W-1:0] reqr,
                                      logic [ADDR_W-1:0] addr,
                                      logic [ST_W-1:0] s0, logic [ST_W-1:0] s1,
                                      logic [ST_W-1:0] s2, logic [ST_W-1:0] s3);
        t_req r;
        r.req_type      = op;
        r.requester     = reqr;
        r.block_address = addr;
        r.state_cache0  = s0;
        r.state_cache1  = s1;
        r.state_cache2  = s2;
        r.state_cache3  = s3;
        return r;
    endfunction

    // lean toward invalid lines so sole-holder evictions and clean misses show up
    function automatic logic [ST_W-1:0] random_state();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 9)
            return ST_I;
        else if (roll < 19)
            return ST_W'($urandom_range(ST_S, ST_M));
        else
            return ST_W'($urandom_range(ST_RSVD5, ST_RSVD7));
    endfunction

    function automatic t_req random_request();
        logic [OP_W-1:0] op;
        op = ($urandom_range(0, 15) == 0) ? OP_W'($urandom_range(OP_RSVD6, OP_RSVD7))
                                          : OP_W'($urandom_range(OP_NONE, OP_EVICT));
        return make_req(op, REQR_W'($urandom_range(0, 3)), $urandom,
                        random_state(), random_state(), random_state(), random_state());
    endfunction

    task automatic push_request(input t_req r);
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= r.req_type;
        req_ch.requester     <= r.requester;
        req_ch.block_address <= r.block_address;
        req_ch.state_cache0  <= r.state_cache0;
        req_ch.state_cache1  <= r.state_cache1;
        req_ch.state_cache2  <= r.state_cache2;
        req_ch.state_cache3  <= r.state_cache3;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1)
            @(posedge i_clk);
        burst_left--;
        requests_sent++;
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_block_bytes(input logic [BSIZE_W-1:0] bytes);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= bytes;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [BSIZE_W-1:0] sizes [NUM_PHASES];
        int                 p;
        int                 n;
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_wdata          <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= OP_NONE;
        req_ch.requester     <= '0;
        req_ch.block_address <= '0;
        req_ch.state_cache0  <= ST_I;
        req_ch.state_cache1  <= ST_I;
        req_ch.state_cache2  <= ST_I;
        req_ch.state_cache3  <= ST_I;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner requests under the reset block size
        push_request(make_req(OP_NONE, 2'd0, 32'h0000_0000, ST_I, ST_S, ST_E, ST_M));
        push_request(make_req(OP_RD_HIT, 2'd3, 32'hFFFF_FFFF, ST_M, ST_I, ST_I, ST_S));
        push_request(make_req(OP_WR_HIT, 2'd1, 32'h1234_5678, ST_S, ST_S, ST_I, ST_S));
        push_request(make_req(OP_RD_MISS, 2'd0, 32'h8000_0000, ST_I, ST_I, ST_I, ST_I));
        push_request(make_req(OP_RD_MISS, 2'd2, 32'h0000_0040, ST_M, ST_E, ST_I, ST_S));
        push_request(make_req(OP_RD_MISS, 2'd1, 32'hDEAD_BEE0, ST_O, ST_I, ST_S, ST_I));
        push_request(make_req(OP_RD_MISS, 2'd3, 32'h5555_5555, ST_I, ST_I, ST_O, ST_I));
        push_request(make_req(OP_WR_MISS, 2'd0, 32'hAAAA_AAAA, ST_I, ST_S, ST_O, ST_E));
        push_request(make_req(OP_WR_MISS, 2'd3, 32'h0F0F_0F0F, ST_M, ST_O, ST_M, ST_M));
        push_request(make_req(OP_WR_MISS, 2'd2, 32'hF0F0_F0F0, ST_I, ST_I, ST_I, ST_I));
        push_request(make_req(OP_EVICT, 2'd0, 32'h0000_1000, ST_M, ST_O, ST_I, ST_I));
        push_request(make_req(OP_EVICT, 2'd1, 32'h0000_2000, ST_I, ST_S, ST_S, ST_I));
        push_request(make_req(OP_EVICT, 2'd3, 32'h0000_3000, ST_I, ST_S, ST_O, ST_E));
        push_request(make_req(OP_EVICT, 2'd2, 32'h0000_4000, ST_I, ST_I, ST_M, ST_I));
        push_request(make_req(OP_EVICT, 2'd0, 32'h0000_5000, ST_E, ST_I, ST_I, ST_E));
        push_request(make_req(OP_RSVD6, 2'd1, 32'h7FFF_FFFF, ST_M, ST_E, ST_S, ST_O));
        push_request(make_req(OP_RSVD7, 2'd2, 32'hFFFF_FFFE, ST_S, ST_I, ST_M, ST_E));
        // undefined line states behave as invalid
        push_request(make_req(OP_RD_MISS, 2'd0, 32'h0000_0001, ST_I, ST_RSVD5, ST_RSVD6,
                              ST_RSVD7));
        push_request(make_req(OP_WR_HIT, 2'd2, 32'h0000_0002, ST_RSVD7, ST_RSVD5, ST_S,
                              ST_M));
        push_request(make_req(OP_EVICT, 2'd1, 32'h0000_0003, ST_RSVD6, ST_O, ST_I, ST_I));
        push_request(make_req(OP_RD_HIT, 2'd0, 32'h0000_0004, ST_RSVD5, ST_M, ST_RSVD7,
                              ST_O));
        wait_idle();

        sizes[0] = 13'd4;
        sizes[1] = 13'd4096;
        sizes[2] = 13'd0;
        sizes[3] = 13'd8191;
        sizes[4] = BSIZE_W'($urandom_range(4, 4096));
        sizes[5] = BSIZE_W'($urandom_range(1, 8191));
        for (p = 0; p < NUM_PHASES; p++) begin
            write_block_bytes(sizes[p]);
            for (n = 0; n < PHASE_ITEMS; n++)
                push_request(random_request());
            wait_idle();
        end

        $display("covered %0d requests with %0d results checked", requests_sent, checked);
        $display("block sizes: reset, 4, 4096, 0, 8191, %0d and %0d", sizes[4], sizes[5]);
        if (fail_count == 0)
            $display("moesi_snoop_transition_unit: match");
        else
            $display("moesi_snoop_transition_unit: mismatch");
        $finish;
    end

endmodule
